### hdl/itda_pkg.sv
// ---------------------------------------------------------------------------
// itda_pkg
// Shared types, constants and helpers for the integer to decimal text block.
// ---------------------------------------------------------------------------
`default_nettype none

package itda_pkg;

  localparam int VALUE_BITS_DEF = 32;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // decimal digits of 2^(bits-1), the largest magnitude: floor(k*log10(2))+1
  function automatic int num_digits(input int bits);
    return (((bits - 1) * 1233) >> 12) + 1;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture the input value
    logic dabble;     // one shift-and-add-3 step
    logic drop;       // shift the bcd word up by one digit
    logic put_sign;   // write '-' to the output register
    logic put_digit;  // write the top digit to the output register
    logic put_last;   // mark the written character as final
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic negative;
    logic top_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### hdl/itda_datapath.sv
// ---------------------------------------------------------------------------
// itda_datapath
// Magnitude register, double-dabble bcd word and output character register.
// ---------------------------------------------------------------------------
`default_nettype none

module itda_datapath #(
  parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic signed [VALUE_BITS-1:0] in_value,
  input  wire itda_pkg::cmd_t               cmd,
  output itda_pkg::sts_t                    sts,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                        [7:0] out_character,
  output logic                              out_last
);

  localparam int ND    = itda_pkg::num_digits(VALUE_BITS);
  localparam int BCD_W = 4 * ND;

  logic                  neg_r;
  logic [VALUE_BITS-1:0] mag_r;
  logic [BCD_W-1:0]      bcd_r;
  logic [BCD_W-1:0]      bcd_adj;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag_load;
  logic [3:0]            top_digit;
  logic                  out_valid_r;
  logic [7:0]            out_char_r;
  logic                  out_last_r;
  logic                  put;

  assign raw       = in_value;
  // two's complement negate, unsigned so the most negative value converts
  assign mag_load  = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
  assign top_digit = bcd_r[BCD_W-1 -: 4];
  assign put       = cmd.put_sign | cmd.put_digit;

  always_comb begin
    logic [3:0] dig;
    dig     = 4'd0;
    bcd_adj = bcd_r;
    for (int i = 0; i < ND; i++) begin
      dig = bcd_r[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (dig >= 4'd5) ? (dig + 4'd3) : dig;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= raw[VALUE_BITS-1];
      mag_r <= mag_load;
      bcd_r <= '0;
    end else if (cmd.dabble) begin
      bcd_r <= {bcd_adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
      mag_r <= {mag_r[VALUE_BITS-2:0], 1'b0};
    end else if (cmd.drop || cmd.put_digit) begin
      bcd_r <= bcd_r << 4;
    end
  end

  // output register, lets the next value in while the final beat waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (put) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      out_char_r <= cmd.put_sign ? itda_pkg::CHAR_MINUS
                                 : (itda_pkg::CHAR_ZERO + {4'd0, top_digit});
      out_last_r <= cmd.put_last;
    end
  end

  assign sts.negative = neg_r;
  assign sts.top_zero = (top_digit == 4'd0);
  assign sts.out_free = ~out_valid_r | out_ready;

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

### hdl/itda_ctrl.sv
// ---------------------------------------------------------------------------
// itda_ctrl
// Sequencer: conversion bit count, sign, leading-zero skip and digit emit.
// ---------------------------------------------------------------------------
`default_nettype none

module itda_ctrl #(
  parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire itda_pkg::sts_t sts,
  output itda_pkg::cmd_t      cmd
);

  localparam int ND  = itda_pkg::num_digits(VALUE_BITS);
  localparam int BCW = $clog2(VALUE_BITS);
  localparam int DCW = $clog2(ND + 1);

  itda_pkg::state_t state_r, state_nxt;
  logic [BCW-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DCW-1:0]   dig_cnt_r, dig_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= itda_pkg::ST_IDLE;
      bit_cnt_r <= '0;
      dig_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      dig_cnt_r <= dig_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      itda_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          bit_cnt_nxt = BCW'(VALUE_BITS - 1);
          state_nxt   = itda_pkg::ST_CONV;
        end
      end
      itda_pkg::ST_CONV: begin
        cmd.dabble = 1'b1;
        if (bit_cnt_r == '0) begin
          dig_cnt_nxt = DCW'(ND - 1);
          state_nxt   = sts.negative ? itda_pkg::ST_SIGN : itda_pkg::ST_SKIP;
        end else begin
          bit_cnt_nxt = bit_cnt_r - BCW'(1);
        end
      end
      itda_pkg::ST_SIGN: begin
        if (sts.out_free) begin
          cmd.put_sign = 1'b1;
          state_nxt    = itda_pkg::ST_SKIP;
        end
      end
      itda_pkg::ST_SKIP: begin
        // the units digit is always shown, even when zero
        if (sts.top_zero && (dig_cnt_r != '0)) begin
          cmd.drop    = 1'b1;
          dig_cnt_nxt = dig_cnt_r - DCW'(1);
        end else if (sts.out_free) begin
          cmd.put_digit = 1'b1;
          cmd.put_last  = (dig_cnt_r == '0);
          if (dig_cnt_r == '0) begin
            state_nxt = itda_pkg::ST_IDLE;
          end else begin
            dig_cnt_nxt = dig_cnt_r - DCW'(1);
            state_nxt   = itda_pkg::ST_EMIT;
          end
        end
      end
      itda_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.put_digit = 1'b1;
          cmd.put_last  = (dig_cnt_r == '0);
          if (dig_cnt_r == '0) begin
            state_nxt = itda_pkg::ST_IDLE;
          end else begin
            dig_cnt_nxt = dig_cnt_r - DCW'(1);
          end
        end
      end
      default: begin
        state_nxt = itda_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/int_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed integer to decimal ASCII text, one character per output beat.
// ---------------------------------------------------------------------------
// Usage:
//   in_value is a two's complement integer taken on an in_valid/in_ready
//   beat. Its decimal text leaves on out_character, most significant first,
//   with a leading '-' for negative values and out_last on the final digit.
//   Leading zeros are dropped; zero gives a single '0'.
//   One value is in work at a time. in_ready is high only while idle.
//   The bcd word holds D digits, D being the digit count of 2^(VALUE_BITS-1)
//   (10 at 32 bits). The bit-serial double-dabble loop first shifts in
//   every magnitude bit, then each bcd digit in turn, most significant
//   first, is dropped as a leading zero or emitted. A negative value sends
//   its '-' between the loop and the first digit, and dropped leading
//   zeros delay the first digit.
//   Characters pass through one output register; while the receiver holds
//   out_ready low the next character waits and the one shown holds. The next
//   value is taken while the final character still waits in that register.
//   Synchronous active-low reset returns to idle and empties the output.
// ---------------------------------------------------------------------------
`default_nettype none

module int_to_decimal_ascii #(
  parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [VALUE_BITS-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                        [7:0] out_character,
  output logic                              out_last
);

  itda_pkg::cmd_t cmd;
  itda_pkg::sts_t sts;

  itda_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itda_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

### hdl/itda_checker.sv
// ---------------------------------------------------------------------------
// itda_checker
// Port-level checks for the integer to decimal text block, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module itda_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_character,
  input wire logic       out_last
);

  // a stalled output beat holds its character and flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("output beat changed while stalled");

  // only a minus sign or a decimal digit ever leaves
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == itda_pkg::CHAR_MINUS) ||
                  ((out_character >= itda_pkg::CHAR_ZERO) &&
                   (out_character <= itda_pkg::CHAR_ZERO + 8'd9)))
    else $error("character outside sign and digits");

  // a minus sign never ends the text
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_character == itda_pkg::CHAR_MINUS) |-> !out_last)
    else $error("minus sign flagged as last");

  // a value just taken keeps the input blocked as its conversion starts
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken during conversion");

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_character (out_character),
  .out_last      (out_last)
);

`default_nettype wire
